[rtl/core/prime_test_and_divisor_list_assert.svh]
// assertion macros used by the checker file
// expects signals clk and rst_n in the scope where a macro is used
`ifndef PRIME_TEST_AND_DIVISOR_LIST_ASSERT_SVH
`define PRIME_TEST_AND_DIVISOR_LIST_ASSERT_SVH

// same-cycle implication, off while in reset
`define PTDL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptdl check failed");

// next-cycle implication, off while in reset
`define PTDL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptdl check failed");

`endif

[rtl/core/ptdl_pkg.sv]
// shared types and constants of the prime test and divisor lister
// no dependencies
package ptdl_pkg;

  localparam int VAL_W = 16;
  localparam int DIV_W = 13;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_LIST  = 1'b1;

  // class of a value, settled at the front
  typedef enum logic [1:0] {
    CLS_OOR   = 2'd0,  // zero or above the bound
    CLS_ONE   = 2'd1,  // value one
    CLS_SMALL = 2'd2,  // two or three: no candidates to try
    CLS_NORM  = 2'd3   // candidates 2 .. n/2
  } cls_t;

  typedef struct packed {
    logic kind;
    cls_t cls;
  } job_info_t;

  // tag travelling with each slot of the modulus pipeline
  typedef struct packed {
    logic      mark;  // end-of-job slot, no candidate
    job_info_t info;
  } slot_tag_t;

endpackage

[rtl/core/ptdl_queue.sv]
// two-entry job queue between front and back
// depends on nothing
module ptdl_queue #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/ptdl_front.sv]
// front: accepts items, keeps the last queried value, classifies jobs
// depends on ptdl_pkg
module ptdl_front
  import ptdl_pkg::*;
#(
  parameter int MAX_VALUE = 8192,
  parameter int NW        = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [VAL_W-1:0] in_value,
  output logic             push_valid,
  input  logic             push_ready,
  output job_info_t        push_info,
  output logic [NW-1:0]    push_n
);

  logic [VAL_W-1:0] last_value_r, last_value_nxt;
  logic [VAL_W-1:0] n_sel;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    n_sel = (in_kind == KIND_QUERY) ? in_value : last_value_r;
    push_info.kind = in_kind;
    if (n_sel == '0 || n_sel > VAL_W'(MAX_VALUE)) begin
      push_info.cls = CLS_OOR;
    end else if (n_sel == VAL_W'(1)) begin
      push_info.cls = CLS_ONE;
    end else if (n_sel < VAL_W'(4)) begin
      push_info.cls = CLS_SMALL;
    end else begin
      push_info.cls = CLS_NORM;
    end
    push_n = NW'(n_sel);
    last_value_nxt = last_value_r;
    if (in_valid && in_ready && in_kind == KIND_QUERY) begin
      last_value_nxt = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_value_r <= VAL_W'(1);
    end else begin
      last_value_r <= last_value_nxt;
    end
  end

endmodule

[rtl/core/ptdl_mod_pipe.sv]
// modulus pipeline: one restoring step per stage, one candidate per cycle while en is high
// depends on ptdl_pkg
module ptdl_mod_pipe
  import ptdl_pkg::*;
#(
  parameter int NW = 14,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_v,
  input  slot_tag_t     in_tag,
  input  logic [NW-1:0] in_n,
  input  logic [DW-1:0] in_d,
  output logic          out_v,
  output slot_tag_t     out_tag,
  output logic [DW-1:0] out_d,
  output logic          out_hit
);

  logic [NW-1:0] v_r;
  logic [NW-1:0] v_nxt;
  slot_tag_t     tag_r   [NW];
  slot_tag_t     tag_nxt [NW];
  logic [NW-1:0] n_r     [NW];
  logic [NW-1:0] n_nxt   [NW];
  logic [DW-1:0] d_r     [NW];
  logic [DW-1:0] d_nxt   [NW];
  logic [DW-1:0] rem_r   [NW];
  logic [DW-1:0] rem_nxt [NW];

  always_comb begin
    logic [DW:0]   sh;
    logic [DW-1:0] rem_p;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        v_nxt[k]   = in_v;
        tag_nxt[k] = in_tag;
        n_nxt[k]   = in_n;
        d_nxt[k]   = in_d;
        rem_p      = '0;
      end else begin
        v_nxt[k]   = v_r[k-1];
        tag_nxt[k] = tag_r[k-1];
        n_nxt[k]   = n_r[k-1];
        d_nxt[k]   = d_r[k-1];
        rem_p      = rem_r[k-1];
      end
      // bring down the next bit of n, subtract when it fits
      sh = {rem_p, n_nxt[k][NW-1-k]};
      if (sh >= {1'b0, d_nxt[k]}) begin
        sh = sh - {1'b0, d_nxt[k]};
      end
      rem_nxt[k] = sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NW; k++) begin
        tag_r[k] <= tag_nxt[k];
        n_r[k]   <= n_nxt[k];
        d_r[k]   <= d_nxt[k];
        rem_r[k] <= rem_nxt[k];
      end
    end
  end

  assign out_v   = v_r[NW-1];
  assign out_tag = tag_r[NW-1];
  assign out_d   = d_r[NW-1];
  assign out_hit = (rem_r[NW-1] == '0);

endmodule

[rtl/core/ptdl_back.sv]
// back: candidate sequencer, modulus pipeline, result collection, output register
// depends on ptdl_pkg and ptdl_mod_pipe
module ptdl_back
  import ptdl_pkg::*;
#(
  parameter int NW = 14,
  parameter int DW = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  job_info_t        pop_info,
  input  logic [NW-1:0]    pop_n,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_prime,
  output logic [DIV_W-1:0] out_divisor,
  output logic             out_no_factors,
  output logic             out_out_of_range,
  output logic             out_last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  job_info_t     job_info_r;
  logic [NW-1:0] job_n_r;
  logic [DW-1:0] d_r, d_nxt;
  logic          cand;
  slot_tag_t     iss_tag;

  logic          t_v, t_hit;
  slot_tag_t     t_tag;
  logic [DW-1:0] t_d;

  logic [DW-1:0] pend_r;
  logic          pend_v_r, pend_v_nxt;
  logic          hit_seen_r, hit_seen_nxt;

  logic          emit, out_free, en, is_list;
  logic          res_prime, res_nofac, res_oor, res_last;
  logic [DIV_W-1:0] res_div;

  logic             out_valid_r, out_valid_nxt;
  logic             prime_r, no_factors_r, out_of_range_r, last_r;
  logic [DIV_W-1:0] divisor_r;

  assign pop_ready = (state_r == S_IDLE);

  always_comb begin
    cand = (job_info_r.cls == CLS_NORM) && (NW'(d_r) <= (job_n_r >> 1));
    iss_tag.mark = !cand;
    iss_tag.info = job_info_r;
    state_nxt = state_r;
    d_nxt     = d_r;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          state_nxt = S_RUN;
          d_nxt     = DW'(2);
        end
      end
      S_RUN: begin
        if (en) begin
          if (cand) begin
            d_nxt = d_r + DW'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    if (state_r == S_IDLE && pop_valid) begin
      job_info_r <= pop_info;
      job_n_r    <= pop_n;
    end
  end

  ptdl_mod_pipe #(
    .NW(NW),
    .DW(DW)
  ) u_mod_pipe (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (state_r == S_RUN),
    .in_tag (iss_tag),
    .in_n   (job_n_r),
    .in_d   (d_r),
    .out_v  (t_v),
    .out_tag(t_tag),
    .out_d  (t_d),
    .out_hit(t_hit)
  );

  always_comb begin
    is_list  = (t_tag.info.kind == KIND_LIST);
    emit     = t_v && (t_tag.mark || (t_hit && is_list && pend_v_r));
    out_free = !out_valid_r || out_ready;
    en       = !emit || out_free;

    // result of the slot at the pipeline tail
    res_prime = 1'b0;
    res_div   = '0;
    res_nofac = 1'b0;
    res_oor   = 1'b0;
    res_last  = t_tag.mark;
    if (!t_tag.mark) begin
      res_div = DIV_W'(pend_r);
    end else if (t_tag.info.cls == CLS_OOR) begin
      res_oor = 1'b1;
    end else if (!is_list) begin
      res_prime = (t_tag.info.cls != CLS_ONE) && !hit_seen_r;
    end else if (t_tag.info.cls == CLS_ONE) begin
      res_div = DIV_W'(1);
    end else if (pend_v_r) begin
      res_div = DIV_W'(pend_r);
    end else begin
      res_nofac = 1'b1;
    end

    pend_v_nxt   = pend_v_r;
    hit_seen_nxt = hit_seen_r;
    if (en && t_v) begin
      if (t_tag.mark) begin
        pend_v_nxt   = 1'b0;
        hit_seen_nxt = 1'b0;
      end else if (t_hit) begin
        hit_seen_nxt = 1'b1;
        if (is_list) begin
          pend_v_nxt = 1'b1;
        end
      end
    end

    out_valid_nxt = out_valid_r;
    if (en && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      hit_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      hit_seen_r  <= hit_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && t_v && !t_tag.mark && t_hit && is_list) begin
      pend_r <= t_d;
    end
    if (en && emit) begin
      prime_r        <= res_prime;
      divisor_r      <= res_div;
      no_factors_r   <= res_nofac;
      out_of_range_r <= res_oor;
      last_r         <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_prime        = prime_r;
  assign out_divisor      = divisor_r;
  assign out_no_factors   = no_factors_r;
  assign out_out_of_range = out_of_range_r;
  assign out_last         = last_r;

endmodule

[rtl/core/prime_test_and_divisor_list.sv]
// prime test and divisor lister, top level
// an item passes the job queue, the candidate sequencer, the modulus pipeline and the output register;
//   a value of four or more sweeps candidates 2 .. n/2, out-of-range, one, two and three send only the end slot
// the candidate sequencer takes a new job once it has issued the last job's end slot, feeding one
//   trial divisor a cycle into the shared modulus pipeline unless the output stalls
// reset (rst_n low, synchronous): queue, sequencer and output cleared, last value set to one
module prime_test_and_divisor_list
  import ptdl_pkg::*;
#(
  parameter int MAX_VALUE = 8192
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_prime,
  output logic [DIV_W-1:0] out_divisor,
  output logic             out_no_factors,
  output logic             out_out_of_range,
  output logic             out_last
);

  // width of an in-range value and of a trial divisor (up to n/2 + 1)
  localparam int NW = $clog2(MAX_VALUE + 1);
  localparam int DW = $clog2(MAX_VALUE / 2 + 2);
  localparam int QW = $bits(job_info_t) + NW;

  // front to queue
  logic          f_valid, f_ready;
  job_info_t     f_info;
  logic [NW-1:0] f_n;

  // queue to back
  logic          b_valid, b_ready;
  logic [QW-1:0] b_data;
  job_info_t     b_info;
  logic [NW-1:0] b_n;

  // front: classifies each item and resolves a listing to the last queried value
  ptdl_front #(
    .MAX_VALUE(MAX_VALUE),
    .NW       (NW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_value  (in_value),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_info (f_info),
    .push_n    (f_n)
  );

  // short job queue so front and back stall independently
  ptdl_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_info, f_n}),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data)
  );

  assign b_info = job_info_t'(b_data[QW-1:NW]);
  assign b_n    = b_data[NW-1:0];

  // back: walks candidates 2 .. n/2, one modulus per cycle unless the output stalls, collects divisors;
  // a held divisor is sent once the next one shows up, so the final gets last
  ptdl_back #(
    .NW(NW),
    .DW(DW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (b_valid),
    .pop_ready       (b_ready),
    .pop_info        (b_info),
    .pop_n           (b_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_prime       (out_prime),
    .out_divisor     (out_divisor),
    .out_no_factors  (out_no_factors),
    .out_out_of_range(out_out_of_range),
    .out_last        (out_last)
  );

endmodule

[rtl/core/ptdl_checker.sv]
// port-level checks of the prime test and divisor lister, bound to the top level
// depends on ptdl_pkg and prime_test_and_divisor_list_assert.svh
`include "prime_test_and_divisor_list_assert.svh"

module ptdl_checker
  import ptdl_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_prime,
  input logic [DIV_W-1:0] out_divisor,
  input logic             out_no_factors,
  input logic             out_out_of_range,
  input logic             out_last
);

  // a stalled result stays valid and keeps its divisor and last flag
  `PTDL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_divisor) && $stable(out_last))

  // at most one of the status flags on any result
  `PTDL_ASSERT_IMP(a_one_flag, out_valid, $countones({out_prime, out_no_factors, out_out_of_range}) <= 1)

  // out-of-range, prime and no-factors results stand alone and carry no divisor
  `PTDL_ASSERT_IMP(a_flag_alone, out_valid && (out_prime || out_no_factors || out_out_of_range), out_last && out_divisor == '0)

  // a result with no divisor and no flag is a not-prime query answer, always final
  `PTDL_ASSERT_IMP(a_plain_last, out_valid && out_divisor == '0, out_last)

endmodule

bind prime_test_and_divisor_list ptdl_checker u_ptdl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_prime       (out_prime),
  .out_divisor     (out_divisor),
  .out_no_factors  (out_no_factors),
  .out_out_of_range(out_out_of_range),
  .out_last        (out_last)
);

[dv/prime_test_and_divisor_list_test.sv]
// self-checking testbench for prime_test_and_divisor_list: primality queries and divisor
// listings, checked item by item against a predictor kept inside this module
// depends on ptdl_pkg and the prime_test_and_divisor_list rtl
module prime_test_and_divisor_list_test;
  import ptdl_pkg::*;

  // upper bound of the value range, same as the block default
  localparam int BOUND = 8192;
  // most results one listing can give at this bound (value 7560)
  localparam int MOST_ANSWERS = 62;
  // items never exceed this, used only for the timeout
  localparam int ITEM_CAP = 200;
  // longest receiver stall the stall patterns can plausibly produce
  localparam int LONGEST_STALL = 16;
  // worst item: full candidate sweep, every result stalled, longest sender gap
  localparam longint CYCLE_LIMIT =
    longint'(ITEM_CAP) * (BOUND / 2 + 40 + MOST_ANSWERS * LONGEST_STALL + 16) * 4;
  // quiet time after the last expected result before the verdict
  localparam int DRAIN_CYCLES = 100;
  localparam int ITEM_TARGET = 140;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic             prime;
    logic [DIV_W-1:0] divisor;
    logic             no_factors;
    logic             out_of_range;
    logic             last;
  } answer_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } stall_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_kind = KIND_QUERY;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_prime;
  logic [DIV_W-1:0] out_divisor;
  logic             out_no_factors;
  logic             out_out_of_range;
  logic             out_last;

  // items waiting to be driven, and results owed by the block
  request_t items_to_send[$];
  answer_t  answers_due[$];

  // predictor state: value of the most recent query
  logic [VAL_W-1:0] remembered_value = 16'd1;

  int          items_total = 0;
  int          items_taken = 0;
  int          mismatches = 0;
  longint      cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = READY_ALWAYS;
  int          mode_left = 0;
  logic [7:0]  ready_pattern = 8'hff;

  prime_test_and_divisor_list #(
    .MAX_VALUE(BOUND)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_prime       (out_prime),
    .out_divisor     (out_divisor),
    .out_no_factors  (out_no_factors),
    .out_out_of_range(out_out_of_range),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit within_bound(int unsigned n);
    return n != 0 && n <= BOUND;
  endfunction

  // smallest divisor in 2 .. n/2, or 0 when there is none
  function automatic int unsigned smallest_divisor(int unsigned n);
    int unsigned d;
    for (d = 2; d <= n / 2; d++) begin
      if (n % d == 0) return d;
    end
    return 0;
  endfunction

  // push the results one accepted item owes, updating the remembered value
  function automatic void derive_answers(logic kind, logic [VAL_W-1:0] value);
    answer_t     a;
    int unsigned n;
    int unsigned d;
    int unsigned sd;
    int unsigned top;
    a = '0;
    a.last = 1'b1;
    if (kind == KIND_QUERY) begin
      // a query always gives exactly one result, and stores even a bad value
      remembered_value = value;
      n = value;
      if (!within_bound(n)) a.out_of_range = 1'b1;
      else a.prime = (n >= 2) && (smallest_divisor(n) == 0);
      answers_due.push_back(a);
      return;
    end
    n = remembered_value;
    if (!within_bound(n)) begin
      a.out_of_range = 1'b1;
      answers_due.push_back(a);
      return;
    end
    if (n == 1) begin
      // value one lists itself
      a.divisor = DIV_W'(1);
      answers_due.push_back(a);
      return;
    end
    sd = smallest_divisor(n);
    if (sd == 0) begin
      a.no_factors = 1'b1;
      answers_due.push_back(a);
      return;
    end
    // the largest proper divisor closes the list
    top = n / sd;
    for (d = sd; d <= top; d++) begin
      if (n % d == 0) begin
        a.divisor = d[DIV_W-1:0];
        a.last = (d == top);
        answers_due.push_back(a);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_query(logic [VAL_W-1:0] value);
    request_t r;
    r.kind = KIND_QUERY;
    r.value = value;
    items_to_send.push_back(r);
  endfunction

  // the value field is ignored on a listing, so it gets random bits
  function automatic void add_listing();
    request_t r;
    r.kind = KIND_LIST;
    r.value = VAL_W'($urandom_range(0, 65535));
    items_to_send.push_back(r);
  endfunction

  // mostly small values so the candidate sweep stays short, a few up to the bound
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return VAL_W'($urandom_range(1, 200));
    if (roll < 95) return VAL_W'($urandom_range(201, 2000));
    return VAL_W'($urandom_range(2001, BOUND));
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of items with random gaps, valid held until accepted
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : send_items
    request_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= KIND_QUERY;
      in_value <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      // the item on the port is taken at this edge, predict from what was driven
      if (in_valid && in_ready) begin
        derive_answers(in_kind, in_value);
        items_taken <= items_taken + 1;
      end
      if (in_valid && !in_ready) begin
        // not taken yet, payload stays as it is
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (items_to_send.size() != 0) begin
        next_item = items_to_send.pop_front();
        in_valid <= 1'b1;
        in_kind <= next_item.kind;
        in_value <= next_item.value;
        if (burst_left <= 1) begin
          // new burst; about a quarter of bursts run on with no gap at all
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each accepted result with the oldest one owed
  // ---------------------------------------------------------------------------

  task automatic compare_field(string field, logic [DIV_W-1:0] want, logic [DIV_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    answer_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode <= READY_ALWAYS;
      mode_left <= 0;
      ready_pattern <= 8'hff;
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $error("result with nothing outstanding: divisor %0d last %0d",
                 out_divisor, out_last);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          compare_field("prime", DIV_W'(want.prime), DIV_W'(out_prime));
          compare_field("divisor", want.divisor, out_divisor);
          compare_field("no_factors", DIV_W'(want.no_factors), DIV_W'(out_no_factors));
          compare_field("out_of_range", DIV_W'(want.out_of_range),
                        DIV_W'(out_out_of_range));
          compare_field("last", DIV_W'(want.last), DIV_W'(out_last));
        end
      end
      // receiver switches between always ready, coin flips and a rotating mask
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(20, 200);
        ready_pattern <= 8'($urandom_range(1, 255));
      end else begin
        mode_left <= mode_left - 1;
        if (stall_mode == READY_PATTERN)
          ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
      end
      case (stall_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:      out_ready <= ready_pattern[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // timeout
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("prime_test_and_divisor_list_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // item list, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned roll;

    // listing straight after reset lists the reset value one
    add_listing();
    // value one: not prime, lists itself
    add_query(16'd1);
    add_listing();
    // zero is out of range for both the query and the listing
    add_query(16'd0);
    add_listing();
    // two and three: prime with no candidates to try
    add_query(16'd2);
    add_listing();
    add_query(16'd3);
    add_listing();
    add_query(16'd4);
    add_listing();
    // the bound itself, largest divisor 4096 fills the divisor field
    add_query(16'(BOUND));
    add_listing();
    // just above the bound, and every value bit high
    add_query(16'(BOUND + 1));
    add_listing();
    add_query(16'hffff);
    add_query(16'h5555);
    // largest prime under the bound, a full sweep with no divisor
    add_query(16'd8191);
    add_listing();
    // the value with the longest divisor list
    add_query(16'd7560);
    add_listing();
    // two listings in a row of the same value
    add_listing();

    // random part: mostly query then listing, plus lone items and noise
    while (items_to_send.size() < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        add_query(pick_value());
        add_listing();
        if ($urandom_range(0, 9) == 0) add_listing();
      end else if (roll < 82) begin
        add_query(pick_value());
      end else if (roll < 90) begin
        add_listing();
      end else begin
        // arbitrary 16-bit value, nearly always out of range
        add_query(VAL_W'($urandom_range(0, 65535)));
        if ($urandom_range(0, 1) == 0) add_listing();
      end
    end
    items_total = items_to_send.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // all items accepted and every owed result seen
    while (items_taken != items_total || answers_due.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("prime_test_and_divisor_list_test: clean");
    else
      $display("prime_test_and_divisor_list_test: errors");
    $finish;
  end

endmodule
